// ===== rtl/core/wrapped_monospace_glyph_layout_defines.svh =====
// Assertion macros used by the glyph layout top level.
`ifndef WRAPPED_MONOSPACE_GLYPH_LAYOUT_DEFINES_SVH
`define WRAPPED_MONOSPACE_GLYPH_LAYOUT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WMGL_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph layout check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WMGL_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph layout check failed");

`endif

// ===== rtl/core/wmgl_pkg.sv =====
// Types and constants shared by the glyph layout modules.
`timescale 1ns / 1ps
package wmgl_pkg;
	localparam logic [1:0] KIND_BEGIN = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_SPACE   = 8'd32;

	localparam logic [16:0] UV_ONE = 17'd65536;

	localparam logic [2:0] REG_FIRST_CODE    = 3'd0;
	localparam logic [2:0] REG_LAST_CODE     = 3'd1;
	localparam logic [2:0] REG_ATLAS_COLUMNS = 3'd2;
	localparam logic [2:0] REG_ATLAS_ROWS    = 3'd3;
	localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd4;
	localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd5;
	localparam logic [2:0] REG_LINE_STEP     = 3'd6;
	localparam logic [2:0] REG_WRAP_WIDTH    = 3'd7;

	localparam int DIV_NW      = 25;
	localparam int DIV_DW      = 9;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0]  first_code;
		logic [7:0]  last_code;
		logic [8:0]  atlas_columns;
		logic [8:0]  atlas_rows;
		logic [23:0] glyph_width;
		logic [23:0] glyph_height;
		logic [23:0] line_step;
		logic [31:0] wrap_width;
	} cfg_t;

	typedef struct packed {
		logic        is_end;
		logic        is_space;
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  idx;
		logic [31:0] widest;
		logic [8:0]  count;
	} job_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] quad_x;
		logic [31:0] quad_y;
		logic [23:0] quad_width;
		logic [23:0] quad_height;
		logic [16:0] tex_u0;
		logic [16:0] tex_v0;
		logic [16:0] tex_u1;
		logic [16:0] tex_v1;
		logic [31:0] widest_line;
		logic [8:0]  quads_emitted;
	} res_t;
endpackage

// ===== rtl/core/wmgl_front.sv =====
// Front end: accepts items, tracks the pen and line widths, queues jobs.
`timescale 1ns / 1ps
module wmgl_front #(
	parameter int MAX_QUADS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wmgl_pkg::cfg_t      cfg,
	input  logic                accept,
	input  logic [1:0]          kind,
	input  logic [7:0]          char_code,
	input  logic signed [31:0]  origin_x,
	input  logic signed [31:0]  origin_y,
	output logic                job_push,
	output wmgl_pkg::job_t      job
);
	localparam int CNT_W = $clog2(MAX_QUADS + 1);

	logic [31:0] line_start_q, pen_x_q, pen_y_q, clw_q, widest_q;
	logic [CNT_W-1:0] cnt_q;

	logic is_char, is_end, is_begin, limited, in_range, glyph, newline, wrap;
	logic [32:0] sum_w;
	logic [31:0] clw_sat, widest_fold, pen_y_adv, ls_adv, px_adv;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [23:0] b);
		logic [32:0] s;
		s = {a[31], a} + {9'd0, b};
		return (s[32] != s[31]) ? 32'h7FFF_FFFF : s[31:0];
	endfunction

	always_comb begin
		is_char  = accept && (kind == wmgl_pkg::KIND_CHAR);
		is_end   = accept && (kind == wmgl_pkg::KIND_END);
		is_begin = accept && (kind == wmgl_pkg::KIND_BEGIN);
		limited  = 32'(cnt_q) >= 32'(MAX_QUADS);
		in_range = (char_code >= cfg.first_code) && (char_code <= cfg.last_code);
		newline  = is_char && !limited && (char_code == wmgl_pkg::CODE_NEWLINE);
		glyph    = is_char && !limited && (char_code != wmgl_pkg::CODE_NEWLINE) && in_range;
		sum_w    = {1'b0, clw_q} + {9'd0, cfg.glyph_width};
		wrap     = (sum_w > {1'b0, cfg.wrap_width}) && (clw_q != 32'd0);
		clw_sat  = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
		widest_fold = (clw_q > widest_q) ? clw_q : widest_q;
		pen_y_adv = sat_add(pen_y_q, cfg.line_step);
		ls_adv    = sat_add(line_start_q, cfg.glyph_width);
		px_adv    = sat_add(pen_x_q, cfg.glyph_width);

		job_push     = glyph || is_end;
		job.is_end   = is_end;
		job.is_space = char_code == wmgl_pkg::CODE_SPACE;
		job.x        = wrap ? line_start_q : pen_x_q;
		job.y        = wrap ? pen_y_adv : pen_y_q;
		job.idx      = char_code - cfg.first_code;
		job.widest   = widest_fold;
		job.count    = (32'(cnt_q) > 32'd511) ? 9'd511 : 9'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= '0;
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			clw_q        <= '0;
			widest_q     <= '0;
			cnt_q        <= '0;
		end else if (is_begin) begin
			line_start_q <= origin_x;
			pen_x_q      <= origin_x;
			pen_y_q      <= origin_y;
			clw_q        <= '0;
			widest_q     <= '0;
			cnt_q        <= '0;
		end else if (is_end) begin
			widest_q <= widest_fold;
		end else if (newline) begin
			widest_q <= widest_fold;
			pen_x_q  <= line_start_q;
			pen_y_q  <= pen_y_adv;
			clw_q    <= '0;
		end else if (glyph) begin
			cnt_q <= cnt_q + 1'b1;
			if (wrap) begin
				widest_q <= widest_fold;
				pen_x_q  <= ls_adv;
				pen_y_q  <= pen_y_adv;
				clw_q    <= {8'd0, cfg.glyph_width};
			end else begin
				pen_x_q <= px_adv;
				clw_q   <= clw_sat;
			end
		end
	end
endmodule

// ===== rtl/core/wmgl_fifo.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module wmgl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  wmgl_pkg::job_t wdata,
	input  logic           rd,
	output wmgl_pkg::job_t rdata,
	output logic           full,
	output logic           empty
);
	localparam int DEPTH = wmgl_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	wmgl_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/core/wmgl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wmgl_div #(
	parameter int NW = 25,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] r_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial, diff;
	logic          ge;

	always_comb begin
		trial = {r_q, n_q[NW-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	assign done      = done_q;
	assign quotient  = n_q;
	assign remainder = r_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[NW-2:0], ge};
			r_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end
endmodule

// ===== rtl/core/wmgl_back.sv =====
// Back end: atlas cell and UV computation, result register.
`timescale 1ns / 1ps
module wmgl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wmgl_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  wmgl_pkg::job_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_pop,
	output wmgl_pkg::res_t res
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_IDX, ST_U0, ST_V0, ST_U1, ST_V1, ST_OUT
	} state_t;

	state_t state_q;
	wmgl_pkg::job_t job_q;
	wmgl_pkg::res_t res_q, stage_q, stage_d;
	logic out_valid_q, wait_q;
	logic [7:0] col_q, row_q;
	logic [8:0] cols_e, rows_e, col1, row1;
	logic div_start, div_done;
	logic [wmgl_pkg::DIV_NW-1:0] div_n, div_quot;
	logic [wmgl_pkg::DIV_DW-1:0] div_d, div_rem;
	logic [16:0] uv;

	wmgl_div #(.NW(wmgl_pkg::DIV_NW), .DW(wmgl_pkg::DIV_DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .done(div_done), .quotient(div_quot), .remainder(div_rem)
	);

	always_comb begin
		cols_e = (cfg.atlas_columns == '0) ? 9'd1 : cfg.atlas_columns;
		rows_e = (cfg.atlas_rows == '0) ? 9'd1 : cfg.atlas_rows;
		col1   = {1'b0, col_q} + 9'd1;
		row1   = {1'b0, row_q} + 9'd1;
		div_d  = cols_e;
		div_n  = 25'(job_q.idx);
		case (state_q)
			ST_IDX: begin
				div_n = 25'(job_q.idx);
			end
			ST_U0: begin
				div_n = {1'b0, col_q, 16'd0};
			end
			ST_V0: begin
				div_n = {1'b0, row_q, 16'd0};
				div_d = rows_e;
			end
			ST_U1: begin
				div_n = {col1, 16'd0};
			end
			ST_V1: begin
				div_n = {row1, 16'd0};
				div_d = rows_e;
			end
			default: begin
				div_n = 25'(job_q.idx);
			end
		endcase
		div_start = (state_q != ST_IDLE) && (state_q != ST_OUT) && !wait_q;
		uv = (div_quot > 25'(wmgl_pkg::UV_ONE)) ? wmgl_pkg::UV_ONE : div_quot[16:0];
		q_pop = (state_q == ST_IDLE) && !q_empty;

		// Fresh staging entry for the job at the queue head.
		stage_d = '0;
		stage_d.result_kind = q_head.is_end;
		if (q_head.is_end) begin
			stage_d.widest_line   = q_head.widest;
			stage_d.quads_emitted = q_head.count;
		end else begin
			stage_d.quad_x      = q_head.x;
			stage_d.quad_y      = q_head.y;
			stage_d.quad_width  = cfg.glyph_width;
			stage_d.quad_height = cfg.glyph_height;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			wait_q      <= 1'b0;
			job_q       <= '0;
			stage_q     <= '0;
			res_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else begin
			if ((state_q == ST_OUT) && (!out_valid_q || out_pop)) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			if (div_start) begin
				wait_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						job_q   <= q_head;
						stage_q <= stage_d;
						state_q <= (q_head.is_end || q_head.is_space) ? ST_OUT : ST_IDX;
					end
				end
				ST_IDX: begin
					if (wait_q && div_done) begin
						col_q   <= div_rem[7:0];
						row_q   <= div_quot[7:0];
						wait_q  <= 1'b0;
						state_q <= ST_U0;
					end
				end
				ST_U0: begin
					if (wait_q && div_done) begin
						stage_q.tex_u0 <= uv;
						wait_q  <= 1'b0;
						state_q <= ST_V0;
					end
				end
				ST_V0: begin
					if (wait_q && div_done) begin
						stage_q.tex_v0 <= uv;
						wait_q  <= 1'b0;
						state_q <= ST_U1;
					end
				end
				ST_U1: begin
					if (wait_q && div_done) begin
						stage_q.tex_u1 <= uv;
						wait_q  <= 1'b0;
						state_q <= ST_V1;
					end
				end
				ST_V1: begin
					if (wait_q && div_done) begin
						stage_q.tex_v1 <= uv;
						wait_q  <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_pop) begin
						res_q   <= stage_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/wrapped_monospace_glyph_layout.sv =====
// Top level of the wrapped monospace glyph layout block.
// A textured glyph reaches the result ports after five divisions on the one shared
// divider (atlas cell, u0, v0, u1, v1); space and end skip the divisions.
// The back end finishes one job before it takes the next; begin, newline and
// skipped items are taken whenever the job queue has room.
// Reset: arst_n clears the pen, line widths, quad count, queue and result, and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "wrapped_monospace_glyph_layout_defines.svh"
module wrapped_monospace_glyph_layout #(
	parameter int MAX_QUADS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	// item input
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [7:0]         char_code,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	// result output
	output logic               empty,
	input  logic               pop,
	output logic               result_kind,
	output logic signed [31:0] quad_x,
	output logic signed [31:0] quad_y,
	output logic [23:0]        quad_width,
	output logic [23:0]        quad_height,
	output logic [16:0]        tex_u0,
	output logic [16:0]        tex_v0,
	output logic [16:0]        tex_u1,
	output logic [16:0]        tex_v1,
	output logic [31:0]        widest_line,
	output logic [8:0]         quads_emitted
);
	wmgl_pkg::cfg_t cfg_q;
	wmgl_pkg::job_t job, q_head;
	wmgl_pkg::res_t res;
	logic accept, job_push, q_full, q_empty, q_pop, out_valid;

	// Register file: written any time, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_code    <= 8'd32;
			cfg_q.last_code     <= 8'd126;
			cfg_q.atlas_columns <= 9'd16;
			cfg_q.atlas_rows    <= 9'd6;
			cfg_q.glyph_width   <= 24'd2048;
			cfg_q.glyph_height  <= 24'd4096;
			cfg_q.line_step     <= 24'd4096;
			cfg_q.wrap_width    <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				wmgl_pkg::REG_FIRST_CODE:    cfg_q.first_code    <= cfg_wdata[7:0];
				wmgl_pkg::REG_LAST_CODE:     cfg_q.last_code     <= cfg_wdata[7:0];
				wmgl_pkg::REG_ATLAS_COLUMNS: cfg_q.atlas_columns <= cfg_wdata[8:0];
				wmgl_pkg::REG_ATLAS_ROWS:    cfg_q.atlas_rows    <= cfg_wdata[8:0];
				wmgl_pkg::REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_wdata[23:0];
				wmgl_pkg::REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= cfg_wdata[23:0];
				wmgl_pkg::REG_LINE_STEP:     cfg_q.line_step     <= cfg_wdata[23:0];
				wmgl_pkg::REG_WRAP_WIDTH:    cfg_q.wrap_width    <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Take an item whenever the job queue has room; items that give no result
	// only update the pen state in the front end.
	assign full   = q_full;
	assign accept = push && !q_full;

	wmgl_front #(.MAX_QUADS(MAX_QUADS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .accept(accept), .kind(kind),
		.char_code(char_code), .origin_x(origin_x), .origin_y(origin_y),
		.job_push(job_push), .job(job)
	);

	// Decouple pen tracking from the slow UV work.
	wmgl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(job_push), .wdata(job), .rd(q_pop),
		.rdata(q_head), .full(q_full), .empty(q_empty)
	);

	// Compute atlas cell and UVs, hold the finished item until popped.
	wmgl_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_empty(q_empty), .q_head(q_head),
		.q_pop(q_pop), .out_valid(out_valid), .out_pop(pop), .res(res)
	);

	assign empty         = !out_valid;
	assign result_kind   = res.result_kind;
	assign quad_x        = res.quad_x;
	assign quad_y        = res.quad_y;
	assign quad_width    = res.quad_width;
	assign quad_height   = res.quad_height;
	assign tex_u0        = res.tex_u0;
	assign tex_v0        = res.tex_v0;
	assign tex_u1        = res.tex_u1;
	assign tex_v1        = res.tex_v1;
	assign widest_line   = res.widest_line;
	assign quads_emitted = res.quads_emitted;

	`WMGL_CHECK(a_summary_no_quad, !empty && result_kind, quad_x == 32'd0 && tex_u0 == 17'd0 && tex_v1 == 17'd0)
	`WMGL_CHECK(a_quad_no_summary, !empty && !result_kind, widest_line == 32'd0 && quads_emitted == 9'd0)
	`WMGL_CHECK(a_uv_bounded, !empty, tex_u0 <= 17'd65536 && tex_v0 <= 17'd65536 && tex_u1 <= 17'd65536 && tex_v1 <= 17'd65536)
	`WMGL_CHECK_NEXT(a_end_queued, push && !full && kind == wmgl_pkg::KIND_END, !q_empty)
endmodule
